@@ design/vag_adpcm_decoder_unit_assert.svh @@
// Assertion macros shared by the VAG ADPCM decoder RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef VAG_ADPCM_DECODER_UNIT_ASSERT_SVH
`define VAG_ADPCM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define VAG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vag_adpcm: same-cycle check failed");

// next-cycle implication
`define VAG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vag_adpcm: next-cycle check failed");

`endif

@@ design/vag_pkg.sv @@
// Shared types, constants and coefficient lookup for the VAG ADPCM decoder.
// No dependencies; used by every module of the decoder.
package vag_pkg;

  localparam int BLOCK_BYTES      = 16;
  localparam int POS_W            = $clog2(BLOCK_BYTES);
  localparam int HISTORY_BITS_DEF = 32;
  localparam int QUEUE_DEPTH      = 4;
  localparam int FRAC_BITS        = 6;
  localparam int SHIFT_MAX        = 12;
  localparam int PRED_MAX         = 4;
  localparam int COEF_W           = 8;

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
  localparam logic [4:0]       SHIFT_BASE = 5'(SHIFT_MAX + FRAC_BITS);

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic [3:0] nib_hi;
    logic [3:0] nib_lo;
    logic [2:0] sel;
    logic [3:0] shift;
    logic       last;
    logic       clear;
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_HOLD
  } back_state_t;

  function automatic logic signed [COEF_W-1:0] coef_one(input logic [2:0] sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_two(input logic [2:0] sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ design/vag_adpcm_decoder_unit.sv @@
// Top level of the VAG ADPCM decoder: front end, request queue, back end.
// Depends on vag_pkg, vag_front, vag_queue and vag_back.
//
// Usage:
//   s_axis carries the ADPCM stream one byte per request; s_axis_tuser marks
//   the first byte of a new stream and clears the prediction history.
//   Blocks are 16 bytes: a header byte (predictor, shift), a flags byte
//   (bit 0 marks the final block) and 14 data bytes.
//   m_axis returns one request per data byte: two 16-bit PCM samples, high
//   nibble first, with tlast on the last data byte of the final block.
//   After the final block, bytes are dropped until the next stream start.
// Dataflow:
//   Header, flags and dropped bytes are consumed by the front end and never queued.
//   A data byte passes the queue, is taken by the back end, and reaches m_axis
//   after two multiply/accumulate passes (one per nibble) and the output load;
//   the back end takes no new data byte until the previous one is loaded out.
//   A 4-entry queue lets the front end keep taking bytes while the back end
//   or the receiver stalls; s_axis_tready drops only when the queue is full.
// Reset:
//   rst clears block position, flags, history, queue and output valid.
module vag_adpcm_decoder_unit import vag_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] first_sample, [31:16] second_sample
  output logic        m_axis_tlast
);

  entry_t      push_data;
  entry_t      pop_data;
  logic        push;
  logic        pop;
  logic        full;
  logic        nonempty;
  logic [15:0] first_sample;
  logic [15:0] second_sample;

  vag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  vag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  vag_back #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (nonempty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_first  (first_sample),
    .out_second (second_sample),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {second_sample, first_sample};

endmodule

@@ design/vag_front.sv @@
// Front end: tracks block position and header fields, forwards data bytes.
// Depends on vag_pkg.
module vag_front import vag_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       push,
  output entry_t     push_data,
  input  logic       full
);

  logic [POS_W-1:0] pos;
  logic [2:0]       sel;
  logic [3:0]       shift;
  logic             fin;
  logic             stopped;
  logic             pend_clr;

  logic [POS_W-1:0] pos_next;
  logic [2:0]       sel_next;
  logic [3:0]       shift_next;
  logic             fin_next;
  logic             stopped_next;
  logic             pend_clr_next;

  logic             accept;
  logic [POS_W-1:0] eff_pos;
  logic             eff_stop;
  logic             eff_fin;
  logic             data_byte;
  logic [3:0]       hdr_pred;
  logic [3:0]       hdr_shift;

  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;
  assign eff_pos   = in_start ? POS_HEADER : pos;
  assign eff_stop  = in_start ? 1'b0 : stopped;
  assign eff_fin   = in_start ? 1'b0 : fin;
  assign data_byte = (eff_pos != POS_HEADER) && (eff_pos != POS_FLAGS);
  assign hdr_pred  = in_byte[7:4];
  assign hdr_shift = in_byte[3:0];

  assign push = accept && !eff_stop && data_byte;

  always_comb begin
    push_data.nib_hi = in_byte[7:4];
    push_data.nib_lo = in_byte[3:0];
    push_data.sel    = sel;
    push_data.shift  = shift;
    push_data.last   = (eff_pos == POS_LAST) && eff_fin;
    push_data.clear  = pend_clr || in_start;
  end

  always_comb begin
    pos_next      = pos;
    sel_next      = sel;
    shift_next    = shift;
    fin_next      = fin;
    stopped_next  = stopped;
    pend_clr_next = pend_clr;
    if (accept) begin
      fin_next      = eff_fin;
      stopped_next  = eff_stop;
      pend_clr_next = pend_clr || in_start;
      if (!eff_stop) begin
        pos_next = (eff_pos == POS_LAST) ? POS_HEADER : eff_pos + POS_W'(1);
        if (eff_pos == POS_HEADER) begin
          sel_next   = (hdr_pred > 4'(PRED_MAX)) ? 3'd0 : hdr_pred[2:0];
          shift_next = (hdr_shift > 4'(SHIFT_MAX)) ? 4'(SHIFT_MAX) : hdr_shift;
        end else if (eff_pos == POS_FLAGS) begin
          fin_next = in_byte[0];
        end else begin
          pend_clr_next = 1'b0;
          if (push_data.last) begin
            stopped_next = 1'b1;
          end
        end
      end else begin
        pos_next = eff_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HEADER;
      sel      <= 3'd0;
      shift    <= 4'd0;
      fin      <= 1'b0;
      stopped  <= 1'b0;
      pend_clr <= 1'b0;
    end else begin
      pos      <= pos_next;
      sel      <= sel_next;
      shift    <= shift_next;
      fin      <= fin_next;
      stopped  <= stopped_next;
      pend_clr <= pend_clr_next;
    end
  end

endmodule

@@ design/vag_queue.sv @@
// Short queue of decoded work requests between front and back end.
// Depends on vag_pkg and the assertion macro header.
`include "vag_adpcm_decoder_unit_assert.svh"
module vag_queue import vag_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   nonempty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != CNT_W'(0));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `VAG_ASSERT_IMP(a_no_overflow, push && !pop, count != CNT_W'(QUEUE_DEPTH))
  `VAG_ASSERT_IMP(a_no_underflow, pop, count != CNT_W'(0))
  `VAG_ASSERT_IMP(a_push_not_full, push, !full)

endmodule

@@ design/vag_back.sv @@
// Back end: two-tap prediction, saturation and sample output register.
// Depends on vag_pkg and the assertion macro header.
`include "vag_adpcm_decoder_unit_assert.svh"
module vag_back import vag_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_first,
  output logic [15:0] out_second,
  output logic        out_last
);

  localparam int W  = HISTORY_BITS;
  localparam int PW = W + COEF_W;
  localparam int SW = W + 4;
  localparam int QW = W - FRAC_BITS;

  back_state_t state, state_next;

  entry_t                cur;
  logic                  nib_idx;
  logic signed [W-1:0]   hist1;
  logic signed [W-1:0]   hist2;
  logic signed [PW-1:0]  prod1;
  logic signed [PW-1:0]  prod2;
  logic [15:0]           samp0;
  logic [15:0]           samp1;

  logic                  out_free;
  logic                  take;
  logic                  load_out;
  logic                  do_mul;
  logic                  do_add;

  logic signed [COEF_W-1:0] c1;
  logic signed [COEF_W-1:0] c2;
  logic signed [PW-1:0]     h1x;
  logic signed [PW-1:0]     h2x;
  logic signed [PW-1:0]     c1x;
  logic signed [PW-1:0]     c2x;
  logic signed [PW-1:0]     p1s;
  logic signed [PW-1:0]     p2s;
  logic [3:0]               nib;
  logic [4:0]               shamt;
  logic signed [SW-1:0]     base;
  logic signed [SW-1:0]     sum;
  logic signed [W-1:0]      hsat;
  logic signed [QW-1:0]     q;
  logic [15:0]              sample;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  state_next = q_valid ? B_MUL : B_IDLE;
      B_MUL:   state_next = B_ADD;
      B_ADD:   state_next = nib_idx ? B_HOLD : B_MUL;
      B_HOLD: begin
        if (out_free) begin
          state_next = q_valid ? B_MUL : B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    load_out = 1'b0;
    do_mul   = 1'b0;
    do_add   = 1'b0;
    case (state)
      B_IDLE:  take = q_valid;
      B_MUL:   do_mul = 1'b1;
      B_ADD:   do_add = 1'b1;
      B_HOLD: begin
        load_out = out_free;
        take     = out_free && q_valid;
      end
      default: take = 1'b0;
    endcase
  end

  assign q_pop = take;

  // prediction products
  assign c1  = coef_one(cur.sel);
  assign c2  = coef_two(cur.sel);
  assign h1x = {{COEF_W{hist1[W-1]}}, hist1};
  assign h2x = {{COEF_W{hist2[W-1]}}, hist2};
  assign c1x = {{W{c1[COEF_W-1]}}, c1};
  assign c2x = {{W{c2[COEF_W-1]}}, c2};

  // floor divide by 64, add scaled nibble, saturate
  assign p1s   = prod1 >>> FRAC_BITS;
  assign p2s   = prod2 >>> FRAC_BITS;
  assign nib   = nib_idx ? cur.nib_lo : cur.nib_hi;
  assign shamt = SHIFT_BASE - {1'b0, cur.shift};
  assign base  = $signed({{(SW-4){nib[3]}}, nib}) <<< shamt;
  assign sum   = base + p1s[SW-1:0] + p2s[SW-1:0];

  always_comb begin
    if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
      hsat = sum[W-1:0];
    end else if (sum[SW-1]) begin
      hsat = {1'b1, {(W-1){1'b0}}};
    end else begin
      hsat = {1'b0, {(W-1){1'b1}}};
    end
  end

  // divide by 64 toward zero, clamp to 16 bits
  always_comb begin
    q = hsat[W-1:FRAC_BITS];
    if (hsat[W-1] && hsat[FRAC_BITS-1:0] != '0) begin
      q = q + QW'(1);
    end
    if (q[QW-1:15] == '0 || q[QW-1:15] == '1) begin
      sample = q[15:0];
    end else if (q[QW-1]) begin
      sample = SAMPLE_MIN;
    end else begin
      sample = SAMPLE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      nib_idx   <= 1'b0;
      hist1     <= '0;
      hist2     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        nib_idx <= 1'b0;
        if (q_data.clear) begin
          hist1 <= '0;
          hist2 <= '0;
        end
      end
      if (do_add) begin
        hist2   <= hist1;
        hist1   <= hsat;
        nib_idx <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
    if (do_mul) begin
      prod1 <= h1x * c1x;
      prod2 <= h2x * c2x;
    end
    if (do_add) begin
      if (nib_idx) begin
        samp1 <= sample;
      end else begin
        samp0 <= sample;
      end
    end
    if (load_out) begin
      out_first  <= samp0;
      out_second <= samp1;
      out_last   <= cur.last;
    end
  end

  `VAG_ASSERT_NXT(a_hist_shift, state == B_ADD, hist2 == $past(hist1))
  `VAG_ASSERT_IMP(a_hold_second, state == B_HOLD, nib_idx == 1'b1)
  `VAG_ASSERT_NXT(a_load_valid, load_out, out_valid)

endmodule
